[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the joint limit weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/jlw_pkg.sv]
// Package with word types, codes, constants and reset limits of the joint limit weight block.
package jlw_pkg;

  // Default number of limited joints.
  localparam int LIMITED_JOINTS_DEF = 7;

  // Width of the serial multiplier and of the gradient divisor.
  localparam int MUL_W = 140;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [9:0]  BETA_RESET = 10'd50;
  localparam logic [31:0] GRAD_MAX   = 32'hFFFF_FFFF;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  // Input word.
  typedef struct packed {
    logic               req_type;
    logic [2:0]         joint_index;
    logic signed [31:0] position;
    logic signed [31:0] limit_low;
    logic signed [31:0] limit_high;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  result_joint;
    logic [16:0] weight;
    logic [31:0] gradient;
    logic        saturated;
  } out_word_t;

  // Lower limit after reset, Q4.28; joints past the fourth use the last entry.
  function automatic logic signed [31:0] reset_low(input int i);
    logic signed [31:0] v;
    case (i)
      0:       v = 32'sd0;
      1:       v = -32'sd468508254;
      2:       v = -32'sd421657428;
      3:       v = 32'sd0;
      default: v = -32'sd1686629713;
    endcase
    return v;
  endfunction

  // Upper limit after reset, Q4.28.
  function automatic logic signed [31:0] reset_high(input int i);
    logic signed [31:0] v;
    case (i)
      0:       v = 32'sd67108864;
      1:       v = 32'sd4685083;
      2:       v = 32'sd70276238;
      3:       v = 32'sd843314857;
      default: v = 32'sd1686629713;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/joint_limit_weight.sv]
// Top level of the joint limit weight block: limit table, serial multiplier, dividers, root.
//
//   channel  ports                              word type
//   input    in_valid  in_stall  in_word        jlw_pkg::in_word_t
//   output   out_valid out_stall out_word       jlw_pkg::out_word_t
//   config   cfg_wr_en cfg_wr_data              beta, 10 bits
//
// A write word updates the limit table and yields no result. An evaluate word passes from
// acceptance to result through setup, the shift-add multiplier (five products), a range
// check, the gradient divider (skipped on saturation), a compare, the weight divider, the
// root and the handover; the weight steps are skipped when the gradient shrank. Reset is
// synchronous on rst_n, loads the default limits and beta and clears the stored gradients.
// in_stall is high until the handover; a result waiting under out_stall only holds the next word in its handover step.
`include "assert_macros.svh"

module joint_limit_weight #(
  parameter int LIMITED_JOINTS = jlw_pkg::LIMITED_JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jlw_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output jlw_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [9:0]         cfg_wr_data
);

  // Only eight joints are reachable through the index field.
  localparam int Depth = (LIMITED_JOINTS < 8) ? LIMITED_JOINTS : 8;
  localparam int IW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int W     = jlw_pkg::MUL_W;
  localparam int RW    = W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_DIVCHK, ST_DIVG, ST_DECIDE, ST_DIVW, ST_SQRT, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_DD, PH_DA, PH_BC, PH_BB, PH_BETA
  } phase_t;

  state_t state_r;
  phase_t phase_r;

  logic signed [31:0] lo_tab_r [Depth];
  logic signed [31:0] hi_tab_r [Depth];
  logic [31:0]        pg_r     [Depth];
  logic [9:0]         beta_r;

  logic [2:0]         idx_r;
  logic signed [31:0] q_r, lo_r, hi_r;
  logic [31:0]        b_r, c_r;
  logic [32:0]        a_r;
  logic [W-1:0]       mc_r, acc_r, num_r, den_r;
  logic [63:0]        mp_r;
  logic [6:0]         cnt_r;
  logic [RW-1:0]      rem_r;
  logic [31:0]        g_r;
  logic               sat_r;
  logic [32:0]        s_r, wq_r;
  logic [33:0]        wrem_r, sx_r;
  logic [19:0]        srem_r;
  logic [16:0]        root_r;
  logic               out_valid_r;
  jlw_pkg::out_word_t out_word_r;

  // Magnitude of a 34-bit two's complement value.
  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  logic signed [33:0] d_s, b_s, c_s, a_s;
  logic [33:0]        d_m, b_m, c_m, a_m;
  logic [W-1:0]       mul_sum;
  logic [RW-1:0]      r2, den_x;
  logic               r2_ge;
  logic [33:0]        wr, s_x;
  logic               wr_ge;
  logic [19:0]        sr, trial;
  logic               sr_ge;
  logic               in_acc, idx_ok, out_take;

  // Handshake.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign idx_ok    = (int'(in_word.joint_index) < Depth);
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Differences of position and limits.
  assign d_s = 34'(hi_r) - 34'(lo_r);
  assign b_s = 34'(hi_r) - 34'(q_r);
  assign c_s = 34'(q_r) - 34'(lo_r);
  assign a_s = (34'(q_r) <<< 1) - 34'(hi_r) - 34'(lo_r);
  assign d_m = mag34(d_s);
  assign b_m = mag34(b_s);
  assign c_m = mag34(c_s);
  assign a_m = mag34(a_s);

  // One shift-add step of the multiplier.
  assign mul_sum = acc_r + (mp_r[0] ? mc_r : '0);

  // One restoring step of the gradient divider; the dividend tail is all zeros.
  assign den_x = {1'b0, den_r};
  assign r2    = {rem_r[RW-2:0], 1'b0};
  assign r2_ge = (r2 >= den_x);

  // One restoring step of the weight divider; the dividend is a single one bit.
  assign wr    = {wrem_r[32:0], (cnt_r == 7'd49)};
  assign s_x   = {1'b0, s_r};
  assign wr_ge = (wr >= s_x);

  // One digit step of the square root.
  assign sr    = {srem_r[17:0], sx_r[33:32]};
  assign trial = {1'b0, root_r, 2'b01};
  assign sr_ge = (sr >= trial);

  // State, tables and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DD;
      out_valid_r <= 1'b0;
      beta_r      <= jlw_pkg::BETA_RESET;
      for (int i = 0; i < Depth; i++) begin
        lo_tab_r[i] <= jlw_pkg::reset_low(i);
        hi_tab_r[i] <= jlw_pkg::reset_high(i);
        pg_r[i]     <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        beta_r <= cfg_wr_data;
      end
      // The handover step sets the output valid itself.
      if (out_take && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && idx_ok) begin
            if (in_word.req_type == jlw_pkg::REQ_WRITE) begin
              lo_tab_r[in_word.joint_index[IW-1:0]] <= in_word.limit_low;
              hi_tab_r[in_word.joint_index[IW-1:0]] <= in_word.limit_high;
            end else begin
              idx_r   <= in_word.joint_index;
              q_r     <= in_word.position;
              lo_r    <= lo_tab_r[in_word.joint_index[IW-1:0]];
              hi_r    <= hi_tab_r[in_word.joint_index[IW-1:0]];
              state_r <= ST_PREP;
            end
          end
        end

        ST_PREP: begin
          // First product is the squared limit span.
          b_r     <= b_m[31:0];
          c_r     <= c_m[31:0];
          a_r     <= a_m[32:0];
          mc_r    <= W'(d_m[31:0]);
          mp_r    <= 64'(d_m[31:0]);
          acc_r   <= '0;
          cnt_r   <= 7'd32;
          phase_r <= PH_DD;
          state_r <= ST_MUL;
        end

        ST_MUL: begin
          if (cnt_r != 7'd1) begin
            acc_r <= mul_sum;
            mc_r  <= {mc_r[W-2:0], 1'b0};
            mp_r  <= {1'b0, mp_r[63:1]};
            cnt_r <= cnt_r - 7'd1;
          end else begin
            acc_r <= '0;
            unique case (phase_r)
              PH_DD: begin
                mc_r    <= mul_sum;
                mp_r    <= 64'(a_r);
                cnt_r   <= 7'd33;
                phase_r <= PH_DA;
              end
              PH_DA: begin
                num_r   <= mul_sum;
                mc_r    <= W'(b_r);
                mp_r    <= 64'(c_r);
                cnt_r   <= 7'd32;
                phase_r <= PH_BC;
              end
              PH_BC: begin
                mc_r    <= mul_sum;
                mp_r    <= mul_sum[63:0];
                cnt_r   <= 7'd64;
                phase_r <= PH_BB;
              end
              PH_BB: begin
                mc_r    <= mul_sum;
                mp_r    <= 64'(beta_r);
                cnt_r   <= 7'd10;
                phase_r <= PH_BETA;
              end
              PH_BETA: begin
                // Denominator is 4 * beta * (b*c)^2; numerator is scaled by 2^12.
                den_r   <= {mul_sum[W-3:0], 2'b00};
                rem_r   <= RW'({num_r, 12'b0});
                state_r <= ST_DIVCHK;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end

        ST_DIVCHK: begin
          // A zero divisor or a quotient of 2^32 or more saturates.
          if ((den_r == '0) || (rem_r >= den_x)) begin
            g_r     <= jlw_pkg::GRAD_MAX;
            sat_r   <= 1'b1;
            state_r <= ST_DECIDE;
          end else begin
            sat_r   <= 1'b0;
            cnt_r   <= 7'd32;
            state_r <= ST_DIVG;
          end
        end

        ST_DIVG: begin
          rem_r <= r2_ge ? (r2 - den_x) : r2;
          g_r   <= {g_r[30:0], r2_ge};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_r <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          sat_r <= sat_r || (g_r == jlw_pkg::GRAD_MAX);
          if (g_r >= pg_r[idx_r[IW-1:0]]) begin
            s_r     <= 33'(jlw_pkg::WEIGHT_ONE) + 33'(g_r);
            wrem_r  <= '0;
            wq_r    <= '0;
            cnt_r   <= 7'd49;
            state_r <= ST_DIVW;
          end else begin
            root_r  <= jlw_pkg::WEIGHT_ONE;
            state_r <= ST_FINISH;
          end
        end

        ST_DIVW: begin
          wrem_r <= wr_ge ? (wr - s_x) : wr;
          wq_r   <= {wq_r[31:0], wr_ge};
          cnt_r  <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            sx_r    <= {1'b0, wq_r[31:0], wr_ge};
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= 7'd17;
            state_r <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          srem_r <= sr_ge ? (sr - trial) : sr;
          root_r <= {root_r[15:0], sr_ge};
          sx_r   <= {sx_r[31:0], 2'b00};
          cnt_r  <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_r <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hand over once the output register is free or being emptied.
          if (!out_valid_r || !out_stall) begin
            out_word_r.result_joint <= idx_r;
            out_word_r.weight       <= root_r;
            out_word_r.gradient     <= g_r;
            out_word_r.saturated    <= sat_r;
            out_valid_r             <= 1'b1;
            pg_r[idx_r[IW-1:0]]     <= g_r;
            state_r                 <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and result fields.
  `ASSERT_IMPLY(a_out_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result not from finish")
  `ASSERT_IMPLY(a_sat_is_max, out_valid_r && out_word_r.saturated, out_word_r.gradient == jlw_pkg::GRAD_MAX, "saturated flag without full gradient")
  `ASSERT_IMPLY(a_weight_le_one, out_valid_r, out_word_r.weight <= jlw_pkg::WEIGHT_ONE, "weight above one")
  `ASSERT_NEXT(a_write_stays_idle, in_acc && (in_word.req_type == jlw_pkg::REQ_WRITE), state_r == ST_IDLE, "write word left idle")

endmodule

[tb/sv/joint_limit_weight_test.sv]
// Self-checking testbench for the joint limit weight block.
`timescale 1ns / 100ps

module joint_limit_weight_test;

  localparam int NJ = 7;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD = 3000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  jlw_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  jlw_pkg::out_word_t out_word;
  logic               cfg_wr_en;
  logic [9:0]         cfg_wr_data;

  // Words waiting to be sent and results still owed by the block.
  jlw_pkg::in_word_t  pending_words[$];
  jlw_pkg::out_word_t expected_results[$];

  // Predictor state.
  logic signed [31:0] lim_lo[NJ];
  logic signed [31:0] lim_hi[NJ];
  logic [31:0]        prev_grad[NJ];
  logic [9:0]         beta_now;

  int err_count = 0;
  int results_seen = 0;

  joint_limit_weight #(.LIMITED_JOINTS(NJ)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  // Integer square root, truncated.
  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] one;
    res = 0;
    one = 64'd1 << 62;
    while (one > x) one = one >> 2;
    while (one != 0) begin
      if (x >= res + one) begin
        x = x - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Exact joint limit gradient in Q16.16 with saturation.
  function automatic logic [31:0] limit_gradient(input longint q, input longint lo,
                                                 input longint hi, output logic sat);
    logic [191:0] num;
    logic [191:0] den;
    logic [191:0] quo;
    logic [63:0]  d, a, b, c;
    d = abs64(hi - lo);
    a = abs64(2 * q - hi - lo);
    b = abs64(hi - q);
    c = abs64(q - lo);
    num = ((192'(d) * 192'(d)) * 192'(a)) << 44;
    den = (192'(b) * 192'(b)) * (192'(c) * 192'(c)) * 192'(4 * beta_now);
    sat = 1'b1;
    if (den == 0) return jlw_pkg::GRAD_MAX;
    if (num >= (den << 32)) return jlw_pkg::GRAD_MAX;
    quo = num / den;
    sat = (quo[31:0] == jlw_pkg::GRAD_MAX);
    return quo[31:0];
  endfunction

  // Update the predictor with one accepted word; evaluations owe a result.
  task automatic predict_word(input jlw_pkg::in_word_t w);
    jlw_pkg::out_word_t r;
    logic [31:0] g;
    logic sat;
    logic [63:0] s;
    if (w.joint_index >= NJ) return;
    if (w.req_type == jlw_pkg::REQ_WRITE) begin
      lim_lo[w.joint_index] = w.limit_low;
      lim_hi[w.joint_index] = w.limit_high;
      return;
    end
    g = limit_gradient(longint'(w.position), longint'(lim_lo[w.joint_index]),
                       longint'(lim_hi[w.joint_index]), sat);
    if (g >= prev_grad[w.joint_index]) begin
      s = 64'd65536 + g;
      r.weight = 17'(int_root((64'd1 << 48) / s));
    end else begin
      r.weight = jlw_pkg::WEIGHT_ONE;
    end
    prev_grad[w.joint_index] = g;
    r.result_joint = w.joint_index;
    r.gradient = g;
    r.saturated = sat;
    expected_results.push_back(r);
  endtask

  // Sender: bursts of words separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic next_valid;
    next_valid = (rst_n === 1'b1) ? in_valid : 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      predict_word(pending_words.pop_front());
      next_valid = 1'b0;
    end
    if (rst_n && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        in_word <= pending_words[0];
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: random stall pattern with one long hold-off.
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!hold_done && results_seen == 30) begin
      hold_done = 1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (((results_seen / 64) % 3) == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    jlw_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %p", out_word));
      end else begin
        e = expected_results.pop_front();
        if (out_word.result_joint !== e.result_joint)
          report($sformatf("joint %0d, want %0d", out_word.result_joint, e.result_joint));
        if (out_word.weight !== e.weight)
          report($sformatf("weight %0d, want %0d", out_word.weight, e.weight));
        if (out_word.gradient !== e.gradient)
          report($sformatf("gradient %h, want %h", out_word.gradient, e.gradient));
        if (out_word.saturated !== e.saturated)
          report($sformatf("saturated %b, want %b", out_word.saturated, e.saturated));
      end
    end
  end

  function automatic jlw_pkg::in_word_t make_word(input logic t, input logic [2:0] j,
                                                  input int q, input int lo, input int hi);
    jlw_pkg::in_word_t w;
    w.req_type = t;
    w.joint_index = j;
    w.position = q;
    w.limit_low = lo;
    w.limit_high = hi;
    return w;
  endfunction

  task automatic send_eval(input int j, input int q);
    pending_words.push_back(make_word(jlw_pkg::REQ_EVAL, 3'(j), q,
                                      int'($urandom), int'($urandom)));
  endtask

  task automatic send_limits(input int j, input int lo, input int hi);
    pending_words.push_back(make_word(jlw_pkg::REQ_WRITE, 3'(j), int'($urandom), lo, hi));
  endtask

  // Block until every word is sent and every result returned, then let it settle.
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_beta(input logic [9:0] b);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    beta_now = b;
  endtask

  // Mostly a limit write followed by evaluations inside it, with some noise.
  task automatic random_words(input int count);
    int n;
    int lo, hi, k;
    int j;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 2) begin
        pending_words.push_back(make_word(1'($urandom), 3'($urandom), int'($urandom),
                                          int'($urandom), int'($urandom)));
        n++;
      end else begin
        j = $urandom_range(0, NJ - 1);
        lo = int'($urandom) >>> 2;
        hi = lo + int'($urandom_range(1, 32'h4000_0000));
        send_limits(j, lo, hi);
        k = $urandom_range(1, 4);
        repeat (k) send_eval(j, lo + int'($urandom_range(0, hi - lo)));
        n += k + 1;
      end
    end
  endtask

  localparam logic signed [31:0] RST_LO[NJ] = '{0, -468508254, -421657428, 0,
                                                -1686629713, -1686629713, -1686629713};
  localparam logic signed [31:0] RST_HI[NJ] = '{67108864, 4685083, 70276238, 843314857,
                                                1686629713, 1686629713, 1686629713};

  // Main sequence: reset, directed words, then random phases under several betas.
  initial begin
    logic [9:0] betas[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    beta_now = jlw_pkg::BETA_RESET;
    for (int i = 0; i < NJ; i++) begin
      lim_lo[i] = RST_LO[i];
      lim_hi[i] = RST_HI[i];
      prev_grad[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, first with the reset limits and default beta, then with new limits.
    send_eval(0, 32'sd33554432);
    send_eval(0, 32'sd33554432);
    send_eval(0, 32'sd16777216);
    send_eval(0, 32'sd33554432);
    send_eval(1, -32'sd468508254);
    send_eval(3, 32'sd843314857);
    send_eval(2, 0);
    send_eval(4, 0);
    send_eval(5, 32'h7FFF_FFFF);
    send_eval(6, 32'h8000_0000);
    send_eval(7, 0);
    send_limits(7, 1, 2);
    send_limits(5, 5, 5);
    send_eval(5, 5);
    send_limits(6, 32'h7FFF_FFFF, 32'h8000_0000);
    send_eval(6, 0);
    send_limits(4, 32'h8000_0000, 32'h7FFF_FFFF);
    send_eval(4, 0);
    send_eval(4, 32'sd1073741824);
    send_limits(3, 0, 32'sd268435456);
    send_eval(3, 1);
    send_eval(3, 32'sd134217728);
    random_words(300);
    wait_idle();

    betas = '{10'd1, 10'd1023, 10'd0, 10'($urandom_range(1, 1023)), 10'd50};
    for (int p = 0; p < 5; p++) begin
      write_beta(betas[p]);
      random_words(p == 2 ? 60 : 330);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/jlw_pkg.sv
rtl/core/joint_limit_weight.sv
tb/sv/joint_limit_weight_test.sv
